@@ hdl/pre_pkg.sv @@
// Shared types and constants for the polyline ribbon extrusion block
`timescale 1ns / 1ps

package pre_pkg;

    localparam logic signed [15:0] ONE_Q14        = 16'sd16384;
    localparam logic signed [32:0] NEAR_LIM       = 33'sd256;
    localparam logic [15:0]        LINE_WIDTH_RST = 16'd2560;
    localparam logic [0:0]         IDX_LINE_WIDTH = 1'b0;
    localparam logic [2:0]         CROSS_LAST     = 3'd5;
    localparam logic [2:0]         OFF_LAST       = 3'd2;
    localparam logic [2:0]         EMIT_PAIR_LAST = 3'd1;
    localparam logic [2:0]         EMIT_QUAD_LAST = 3'd3;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               end_of_path;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic               tex_u;
        logic               tex_v;
        logic               last_vertex;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_uvec;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_nvec;

    typedef enum logic [1:0] {
        NSEL_H_NEXT,
        NSEL_H_SCAN,
        NSEL_D,
        NSEL_C
    } t_nsel;

    typedef struct packed {
        logic       mem_wr;
        logic       lat_pi;
        logic       lat_pn;
        logic       up_vert;
        logic       up_norm;
        logic       up_neg;
        logic       dir_norm;
        logic       side_norm;
        logic       side_clr;
        logic       norm_start;
        t_nsel      norm_sel;
        logic       cross_en;
        logic [2:0] cross_idx;
        logic       off_en;
        logic [1:0] off_idx;
        logic       emit;
        logic       emit_right;
        logic       emit_v;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic dz_zero;
        logic dz_pos;
        logic near_next;
        logic near_scan;
        logic norm_done;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/pre_norm.sv @@
// Iterative vector normaliser: sum of squares, bit-serial square root, restoring divides
`timescale 1ns / 1ps

module pre_norm import pre_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_nvec i_vec,
    output logic  o_done,
    output t_uvec o_res
);

    typedef enum logic [4:0] {
        N_IDLE = 5'b00001,
        N_SQ   = 5'b00010,
        N_ROOT = 5'b00100,
        N_DIV  = 5'b01000,
        N_DONE = 5'b10000
    } t_nstate;

    localparam logic [3:0] DB_LOAD   = 4'd15;
    localparam logic [4:0] ROOT_LAST = 5'd30;

    t_nstate     r_state, n_state;
    logic [29:0] r_m [3];
    logic [2:0]  r_sgn;
    logic [4:0]  r_cnt;
    logic [59:0] r_prod;
    logic [61:0] r_sum;
    logic [61:0] r_rad;
    logic [33:0] r_rem;
    logic [30:0] r_root;
    logic [44:0] r_drem;
    logic [44:0] r_dsor;
    logic [14:0] r_q;
    logic [1:0]  r_dc;
    logic [3:0]  r_db;
    t_uvec       r_res;

    logic [33:0] mag [3];
    logic [33:0] mag_or;
    logic [2:0]  sh;
    logic [29:0] m_sq;
    logic [29:0] m_div;
    logic [61:0] sum_nx;
    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        root_ge;
    logic        div_ge;
    logic [14:0] q_nx;
    logic signed [15:0] q_signed;

    always_comb begin
        mag[0] = i_vec.x[33] ? (~i_vec.x + 34'd1) : i_vec.x;
        mag[1] = i_vec.y[33] ? (~i_vec.y + 34'd1) : i_vec.y;
        mag[2] = i_vec.z[33] ? (~i_vec.z + 34'd1) : i_vec.z;
        mag_or = mag[0] | mag[1] | mag[2];
        if (mag_or[33]) begin
            sh = 3'd4;
        end else if (mag_or[32]) begin
            sh = 3'd3;
        end else if (mag_or[31]) begin
            sh = 3'd2;
        end else if (mag_or[30]) begin
            sh = 3'd1;
        end else begin
            sh = 3'd0;
        end
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    m_sq = r_m[0];
            2'd1:    m_sq = r_m[1];
            2'd2:    m_sq = r_m[2];
            default: m_sq = '0;
        endcase
        case (r_dc)
            2'd0:    m_div = r_m[0];
            2'd1:    m_div = r_m[1];
            default: m_div = r_m[2];
        endcase
        sum_nx   = r_sum + 62'(r_prod);
        rem_sh   = {r_rem[31:0], r_rad[61:60]};
        trial    = {1'b0, r_root, 2'b01};
        root_ge  = rem_sh >= trial;
        div_ge   = r_drem >= r_dsor;
        q_nx     = {r_q[13:0], div_ge};
        q_signed = r_sgn[r_dc] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            N_IDLE: if (i_start) n_state = N_SQ;
            N_SQ: begin
                if (r_cnt[1:0] == 2'd3) n_state = (sum_nx == '0) ? N_DONE : N_ROOT;
            end
            N_ROOT: if (r_cnt == ROOT_LAST) n_state = N_DIV;
            N_DIV: if (r_db == 4'd0 && r_dc == 2'd2) n_state = N_DONE;
            N_DONE: n_state = N_IDLE;
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                r_m[0] <= 30'(mag[0] >> sh);
                r_m[1] <= 30'(mag[1] >> sh);
                r_m[2] <= 30'(mag[2] >> sh);
                r_sgn  <= {i_vec.z[33], i_vec.y[33], i_vec.x[33]};
                r_cnt  <= '0;
                r_prod <= '0;
                r_sum  <= '0;
            end
            N_SQ: begin
                r_prod <= m_sq * m_sq;
                r_sum  <= sum_nx;
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    r_rad  <= sum_nx;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                    r_res  <= '0;
                end
            end
            N_ROOT: begin
                r_rem  <= root_ge ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[29:0], root_ge};
                r_rad  <= {r_rad[59:0], 2'b00};
                r_cnt  <= r_cnt + 5'd1;
                r_dc   <= '0;
                r_db   <= DB_LOAD;
            end
            N_DIV: begin
                if (r_db == DB_LOAD) begin
                    r_drem <= {1'b0, m_div, 14'b0} + 45'(r_root >> 1);
                    r_dsor <= {r_root, 14'b0};
                    r_q    <= '0;
                    r_db   <= 4'd14;
                end else begin
                    r_drem <= div_ge ? (r_drem - r_dsor) : r_drem;
                    r_dsor <= r_dsor >> 1;
                    r_q    <= q_nx;
                    if (r_db == 4'd0) begin
                        case (r_dc)
                            2'd0:    r_res.x <= q_signed;
                            2'd1:    r_res.y <= q_signed;
                            default: r_res.z <= q_signed;
                        endcase
                        r_dc <= r_dc + 2'd1;
                        r_db <= DB_LOAD;
                    end else begin
                        r_db <= r_db - 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == N_DONE);
    assign o_res  = r_res;

endmodule

@@ hdl/pre_dp.sv @@
// Datapath: point memory, segment geometry, cross product, offsets and vertex output register
`timescale 1ns / 1ps

module pre_dp import pre_pkg::*; #(
    parameter int MAX_POINTS = 16,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    input  logic [AW-1:0]   i_mem_waddr,
    input  logic [AW-1:0]   i_mem_raddr,
    input  t_in_item        i_in_data,
    input  logic [15:0]     i_line_width,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_data
);

    t_point             r_mem [MAX_POINTS];
    t_point             r_rd;
    t_point             r_pi;
    t_point             r_pn;
    t_uvec              r_up;
    t_uvec              r_dir;
    t_uvec              r_side;
    logic signed [31:0] r_cp [6];
    logic signed [17:0] r_off [3];
    t_out_item          r_out;
    logic               r_out_valid;

    logic signed [32:0] dx_n, dy_n, dz_n, dx_s, dy_s;
    t_nvec              norm_in;
    logic               norm_done;
    t_uvec              norm_res;
    logic signed [15:0] cp_a, cp_b;
    logic signed [15:0] s_sel;
    logic [15:0]        s_mag;
    logic [31:0]        off_prod;
    logic [32:0]        off_rnd;
    logic signed [17:0] off_val;

    function automatic logic near_xy(input logic signed [32:0] dx, input logic signed [32:0] dy);
        return (dx >= -NEAR_LIM) && (dx <= NEAR_LIM) && (dy >= -NEAR_LIM) && (dy <= NEAR_LIM);
    endfunction

    function automatic logic signed [31:0] vtx(input logic signed [31:0] c,
                                               input logic signed [17:0] o,
                                               input logic right);
        logic signed [33:0] s;
        s = right ? (34'(c) + 34'(o)) : (34'(c) - 34'(o));
        if (s > 34'sd2147483647) return 32'sh7FFFFFFF;
        if (s < -34'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[i_mem_waddr] <= '{x: i_in_data.point_x, y: i_in_data.point_y,
                                    z: i_in_data.point_z};
        end
        r_rd <= r_mem[i_mem_raddr];
    end

    always_comb begin
        dx_n = {r_pn.x[31], r_pn.x} - {r_pi.x[31], r_pi.x};
        dy_n = {r_pn.y[31], r_pn.y} - {r_pi.y[31], r_pi.y};
        dz_n = {r_pn.z[31], r_pn.z} - {r_pi.z[31], r_pi.z};
        dx_s = {r_rd.x[31], r_rd.x} - {r_pi.x[31], r_pi.x};
        dy_s = {r_rd.y[31], r_rd.y} - {r_pi.y[31], r_pi.y};
    end

    always_comb begin
        case (i_cmd.norm_sel)
            NSEL_H_NEXT: norm_in = '{x: 34'(dx_n), y: 34'(dy_n), z: '0};
            NSEL_H_SCAN: norm_in = '{x: 34'(dx_s), y: 34'(dy_s), z: '0};
            NSEL_D:      norm_in = '{x: 34'(dx_n), y: 34'(dy_n), z: 34'(dz_n)};
            default:     norm_in = '{x: 34'(r_cp[0]) - 34'(r_cp[1]),
                                     y: 34'(r_cp[2]) - 34'(r_cp[3]),
                                     z: 34'(r_cp[4]) - 34'(r_cp[5])};
        endcase
    end

    pre_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.norm_start),
        .i_vec   (norm_in),
        .o_done  (norm_done),
        .o_res   (norm_res)
    );

    always_comb begin
        case (i_cmd.cross_idx)
            3'd0:    begin cp_a = r_dir.y; cp_b = r_up.z; end
            3'd1:    begin cp_a = r_dir.z; cp_b = r_up.y; end
            3'd2:    begin cp_a = r_dir.z; cp_b = r_up.x; end
            3'd3:    begin cp_a = r_dir.x; cp_b = r_up.z; end
            3'd4:    begin cp_a = r_dir.x; cp_b = r_up.y; end
            3'd5:    begin cp_a = r_dir.y; cp_b = r_up.x; end
            default: begin cp_a = '0;      cp_b = '0;      end
        endcase
        case (i_cmd.off_idx)
            2'd0:    s_sel = r_side.x;
            2'd1:    s_sel = r_side.y;
            default: s_sel = r_side.z;
        endcase
        s_mag    = s_sel[15] ? 16'(-s_sel) : 16'(s_sel);
        off_prod = s_mag * i_line_width;
        off_rnd  = 33'(off_prod) + 33'd8192;
        off_val  = s_sel[15] ? -$signed({1'b0, off_rnd[30:14]}) : $signed({1'b0, off_rnd[30:14]});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_pi) r_pi <= r_rd;
        if (i_cmd.lat_pn) r_pn <= r_rd;
        if (i_cmd.up_vert) begin
            r_up <= '{x: '0, y: '0, z: ONE_Q14};
        end else if (i_cmd.up_norm) begin
            r_up.x <= i_cmd.up_neg ? -norm_res.x : norm_res.x;
            r_up.y <= i_cmd.up_neg ? -norm_res.y : norm_res.y;
            r_up.z <= norm_res.z;
        end
        if (i_cmd.dir_norm) r_dir <= norm_res;
        if (i_cmd.side_clr) begin
            r_side <= '0;
        end else if (i_cmd.side_norm) begin
            r_side <= norm_res;
        end
        if (i_cmd.cross_en) begin
            case (i_cmd.cross_idx)
                3'd0:    r_cp[0] <= cp_a * cp_b;
                3'd1:    r_cp[1] <= cp_a * cp_b;
                3'd2:    r_cp[2] <= cp_a * cp_b;
                3'd3:    r_cp[3] <= cp_a * cp_b;
                3'd4:    r_cp[4] <= cp_a * cp_b;
                default: r_cp[5] <= cp_a * cp_b;
            endcase
        end
        if (i_cmd.off_en) begin
            case (i_cmd.off_idx)
                2'd0:    r_off[0] <= off_val;
                2'd1:    r_off[1] <= off_val;
                default: r_off[2] <= off_val;
            endcase
        end
        if (i_cmd.emit) begin
            r_out.vertex_x    <= vtx(r_pi.x, r_off[0], i_cmd.emit_right);
            r_out.vertex_y    <= vtx(r_pi.y, r_off[1], i_cmd.emit_right);
            r_out.vertex_z    <= vtx(r_pi.z, r_off[2], i_cmd.emit_right);
            r_out.tex_u       <= i_cmd.emit_right;
            r_out.tex_v       <= i_cmd.emit_v;
            r_out.last_vertex <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat = '{dz_zero:   (r_pn.z == r_pi.z),
                      dz_pos:    (r_pn.z > r_pi.z),
                      near_next: near_xy(dx_n, dy_n),
                      near_scan: near_xy(dx_s, dy_s),
                      norm_done: norm_done,
                      out_free:  (!r_out_valid || i_out_ready)};

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/pre_ctrl.sv @@
// Controller: path loading and the per-point sequence of the extrusion pass
`timescale 1ns / 1ps

module pre_ctrl import pre_pkg::*; #(
    parameter int MAX_POINTS = 16,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_end_of_path,
    output logic          o_in_ready,
    input  t_stat         i_stat,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_mem_waddr,
    output logic [AW-1:0] o_mem_raddr
);

    typedef enum logic [13:0] {
        S_LOAD    = 14'b00000000000001,
        S_RD_I    = 14'b00000000000010,
        S_LAT_I   = 14'b00000000000100,
        S_LAT_N   = 14'b00000000001000,
        S_CLASS   = 14'b00000000010000,
        S_SCAN    = 14'b00000000100000,
        S_NORM_UP = 14'b00000001000000,
        S_GO_D    = 14'b00000010000000,
        S_NORM_D  = 14'b00000100000000,
        S_CROSS   = 14'b00001000000000,
        S_GO_C    = 14'b00010000000000,
        S_NORM_C  = 14'b00100000000000,
        S_OFF     = 14'b01000000000000,
        S_EMIT    = 14'b10000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [2:0]    r_k, n_k;
    logic          r_neg, n_neg;

    logic [CW-1:0] cnt_p1, i_p1, j_p1;
    logic          seg, first, full;
    logic [2:0]    emit_last_k;

    always_comb begin
        cnt_p1      = r_cnt + CW'(1);
        i_p1        = CW'(r_i) + CW'(1);
        j_p1        = CW'(r_j) + CW'(1);
        seg         = i_p1 < r_cnt;
        first       = (r_i == '0);
        full        = (cnt_p1 == CW'(MAX_POINTS));
        emit_last_k = (!first && seg) ? EMIT_QUAD_LAST : EMIT_PAIR_LAST;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_neg       = r_neg;
        o_cmd       = '0;
        o_cmd.norm_sel = NSEL_D;
        o_in_ready  = 1'b0;
        o_mem_waddr = r_cnt[AW-1:0];
        o_mem_raddr = r_i;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.mem_wr = 1'b1;
                    n_cnt        = cnt_p1;
                    if (i_end_of_path || full) begin
                        n_i            = '0;
                        o_cmd.side_clr = 1'b1;
                        n_state        = S_RD_I;
                    end
                end
            end
            S_RD_I: n_state = S_LAT_I;
            S_LAT_I: begin
                o_cmd.lat_pi = 1'b1;
                if (seg) begin
                    o_mem_raddr = i_p1[AW-1:0];
                    n_state     = S_LAT_N;
                end else begin
                    n_k     = '0;
                    n_state = S_OFF;
                end
            end
            S_LAT_N: begin
                o_cmd.lat_pn = 1'b1;
                n_state      = S_CLASS;
            end
            S_CLASS: begin
                if (i_stat.dz_zero) begin
                    o_cmd.up_vert = 1'b1;
                    n_state       = S_GO_D;
                end else if (!i_stat.near_next) begin
                    o_cmd.norm_start = 1'b1;
                    o_cmd.norm_sel   = NSEL_H_NEXT;
                    n_neg            = i_stat.dz_pos;
                    n_state          = S_NORM_UP;
                end else begin
                    o_mem_raddr = i_p1[AW-1:0];
                    n_j         = i_p1[AW-1:0];
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.near_scan) begin
                    o_cmd.norm_start = 1'b1;
                    o_cmd.norm_sel   = NSEL_H_SCAN;
                    n_neg            = 1'b1;
                    n_state          = S_NORM_UP;
                end else if (j_p1 < r_cnt) begin
                    o_mem_raddr = j_p1[AW-1:0];
                    n_j         = j_p1[AW-1:0];
                end else begin
                    n_k     = '0;
                    n_state = S_OFF;
                end
            end
            S_NORM_UP: begin
                if (i_stat.norm_done) begin
                    o_cmd.up_norm = 1'b1;
                    o_cmd.up_neg  = r_neg;
                    n_state       = S_GO_D;
                end
            end
            S_GO_D: begin
                o_cmd.norm_start = 1'b1;
                n_state          = S_NORM_D;
            end
            S_NORM_D: begin
                if (i_stat.norm_done) begin
                    o_cmd.dir_norm = 1'b1;
                    n_k            = '0;
                    n_state        = S_CROSS;
                end
            end
            S_CROSS: begin
                o_cmd.cross_en  = 1'b1;
                o_cmd.cross_idx = r_k;
                if (r_k == CROSS_LAST) begin
                    n_state = S_GO_C;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_GO_C: begin
                o_cmd.norm_start = 1'b1;
                o_cmd.norm_sel   = NSEL_C;
                n_state          = S_NORM_C;
            end
            S_NORM_C: begin
                o_cmd.norm_sel = NSEL_C;
                if (i_stat.norm_done) begin
                    o_cmd.side_norm = 1'b1;
                    n_k             = '0;
                    n_state         = S_OFF;
                end
            end
            S_OFF: begin
                o_cmd.off_en  = 1'b1;
                o_cmd.off_idx = r_k[1:0];
                if (r_k == OFF_LAST) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_right = !r_k[0];
                    o_cmd.emit_v     = !seg || (!first && !r_k[1]);
                    o_cmd.emit_last  = !seg && (r_k == EMIT_PAIR_LAST);
                    if (r_k == emit_last_k) begin
                        if (!seg) begin
                            n_cnt   = '0;
                            n_state = S_LOAD;
                        end else begin
                            n_i     = i_p1[AW-1:0];
                            n_state = S_RD_I;
                        end
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_neg   <= n_neg;
        end
    end

endmodule

@@ hdl/polyline_ribbon_extrusion.sv @@
// Top level of the polyline ribbon extrusion block with its register port
//
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
// cfg       input      psel, penable, pwrite        paddr, pwdata, prdata
//
// Loading takes one point per cycle. The marked point, or the MAX_POINTS-th,
// starts a pass in which no point is taken; the time a segment costs is set
// by the shared iterative normaliser (a run: 4 square steps, 31 root steps,
// three divides; a zero vector skips the root and the divides; up to three
// runs per segment, plus a look-ahead scan over later points on a vertical
// step). Vertices leave through one output register; a stalled output holds
// the pass. Reset is synchronous.
`timescale 1ns / 1ps

module polyline_ribbon_extrusion import pre_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_POINTS);

    logic [15:0]   r_line_width;
    t_cmd          cmd;
    t_stat         stat;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
        end else if (psel && penable && pwrite && pready && paddr[2:2] == IDX_LINE_WIDTH) begin
            r_line_width <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2:2] == IDX_LINE_WIDTH) ? {16'b0, r_line_width} : '0;

    pre_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_path (i_in_data.end_of_path),
        .o_in_ready    (o_in_ready),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_mem_waddr   (mem_waddr),
        .o_mem_raddr   (mem_raddr)
    );

    pre_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mem_waddr  (mem_waddr),
        .i_mem_raddr  (mem_raddr),
        .i_in_data    (i_in_data),
        .i_line_width (r_line_width),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
